>>> rtl/core/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int POINT_W     = 21;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POINT_W-1:0] ERR_CHAR     = 21'd63;
    localparam logic [POINT_W-1:0] SUPP_BASE    = 21'h010000;
    localparam logic [POINT_W-1:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [POINT_W-1:0] MAX_BMP      = 21'h00FFFF;
    localparam logic [15:0]        SURR_HI_BASE = 16'hD800;
    localparam logic [15:0]        SURR_LO_BASE = 16'hDC00;

    // What a byte leaves for the back end after any leading error results.
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_POINT,
        TAIL_ERR,
        TAIL_EOS
    } tail_kind_t;

    typedef struct packed {
        logic [2:0]         err_count;
        tail_kind_t         tail;
        logic [POINT_W-1:0] point;
    } usd_job_t;

endpackage

>>> rtl/core/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder giving code points or UTF-16 code units.
// ----------------------------------------------------------------------------
// The slave channel takes one UTF-8 byte per word in s_tdata. Each byte gives
// zero to six result words on the master channel: the value in m_tdata, the
// error and end-of-string flags in m_tuser, and m_tlast on the final word that
// the byte caused. A zero byte ends the string and clears the sequence state.
// cfg_wr_data selects the output form (0 code points, 1 UTF-16 code units);
// write it with cfg_wr_en only while no word is in flight; the block does not
// enforce this. A byte passes the job queue, job registers and output
// register before its first word. One byte per cycle is sustained while each
// byte gives at most one word and m_tready is high; a multi-word byte holds
// the result register until its last word. The front end stops taking bytes
// only when the two-entry job queue is full, so a stalled receiver backs up
// through the output register and the queue. Reset clears the sequence state,
// the queue, the output register and the mode register (code points).
// ----------------------------------------------------------------------------
module utf8_stream_decoder import usd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // output_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,        // [20:0] value, [23:21] zero
    output logic [1:0]  m_tuser,        // [0] is_error, [1] end_of_string
    output logic        m_tlast
);

    logic               mode_reg;
    logic               byte_accept;
    logic               job_push, job_pop;
    logic               queue_not_full, queue_not_empty;
    usd_job_t           new_job, head_job;
    logic [POINT_W-1:0] out_value;
    logic               out_error, out_eos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    assign s_tready    = queue_not_full;
    assign byte_accept = s_tvalid && queue_not_full;

    usd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_accept(byte_accept),
        .in_byte    (s_tdata),
        .job_push   (job_push),
        .job        (new_job)
    );

    usd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (new_job),
        .pop      (job_pop),
        .not_full (queue_not_full),
        .not_empty(queue_not_empty),
        .head_job (head_job)
    );

    usd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .output_mode(mode_reg),
        .job_avail  (queue_not_empty),
        .head_job   (head_job),
        .job_pop    (job_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_error  (out_error),
        .out_eos    (out_eos),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'd0, out_value};
    assign m_tuser = {out_eos, out_error};

`ifndef SYNTHESIS
    // End of string is always the zero value and closes the byte's run.
    a_eos_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 24'd0 && m_tlast && !m_tuser[0]))
        else $error("end-of-string word malformed");

    // Every error word carries ERR_CHAR (63, '?') as its value.
    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 24'd63))
        else $error("error word without replacement character");

    // A word that waits on the receiver stays valid and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("output word changed while stalled");
`endif

endmodule

>>> rtl/core/usd_front.sv
// ----------------------------------------------------------------------------
// usd_front
// Takes one accepted byte a cycle, tracks the pending sequence and turns each
// byte with results into a job: errors, then at most one closing result.
// ----------------------------------------------------------------------------
module usd_front import usd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     byte_accept,
    input  logic [7:0] in_byte,
    output logic     job_push,
    output usd_job_t job
);

    localparam logic [POINT_W-1:0] BAD_THREE [7] = '{
        21'h00D800, 21'h00DB7F, 21'h00DB80, 21'h00DBFF,
        21'h00DC00, 21'h00DF80, 21'h00DFFF
    };

    logic [2:0]         exp_len_reg, exp_len_next;
    logic [2:0]         taken_reg, taken_next;
    logic [POINT_W-1:0] partial_reg, partial_next;

    logic [2:0]         taken_inc;
    logic [POINT_W-1:0] acc_point;
    logic               run_lead;

    function automatic logic point_ok(input logic [2:0] len, input logic [POINT_W-1:0] cp);
        logic ok;
        ok = 1'b0;
        if (len == 3'd2) begin
            ok = (cp >= 21'h80) && (cp <= 21'h7FF);
        end else if (len == 3'd3) begin
            ok = (cp >= 21'h800) && (cp <= 21'hFFFD);
            for (int i = 0; i < 7; i++) begin
                if (cp == BAD_THREE[i]) begin
                    ok = 1'b0;
                end
            end
        end else if (len == 3'd4) begin
            ok = (cp >= SUPP_BASE) && (cp <= MAX_POINT);
        end
        return ok;
    endfunction

    always_comb begin
        exp_len_next = exp_len_reg;
        taken_next   = taken_reg;
        partial_next = partial_reg;
        job          = '0;
        job.tail     = TAIL_NONE;
        run_lead     = 1'b0;
        taken_inc    = taken_reg + 3'd1;
        // Five- and six-byte forms are always rejected, so their bits are dropped.
        acc_point    = (exp_len_reg <= 3'd4) ? {partial_reg[POINT_W-7:0], in_byte[5:0]}
                                             : partial_reg;

        if (exp_len_reg != 3'd0) begin
            if (in_byte[7:6] == 2'b10) begin
                if (taken_inc >= exp_len_reg) begin
                    exp_len_next = 3'd0;
                    taken_next   = 3'd0;
                    partial_next = '0;
                    job.point    = acc_point;
                    job.tail     = point_ok(exp_len_reg, acc_point) ? TAIL_POINT : TAIL_ERR;
                end else begin
                    taken_next   = taken_inc;
                    partial_next = acc_point;
                end
            end else begin
                // Broken sequence: one error per byte taken, then a fresh lead byte.
                job.err_count = taken_reg;
                exp_len_next  = 3'd0;
                taken_next    = 3'd0;
                partial_next  = '0;
                run_lead      = 1'b1;
            end
        end else begin
            run_lead = 1'b1;
        end

        if (run_lead) begin
            if (in_byte == 8'h00) begin
                job.tail = TAIL_EOS;
            end else if (in_byte[7] == 1'b0) begin
                job.tail  = TAIL_POINT;
                job.point = {13'd0, in_byte};
            end else if (in_byte[6] == 1'b0) begin
                job.tail = TAIL_ERR;
            end else begin
                taken_next = 3'd1;
                if (in_byte[5] == 1'b0) begin
                    exp_len_next = 3'd2;
                    partial_next = {16'd0, in_byte[4:0]};
                end else if (in_byte[4] == 1'b0) begin
                    exp_len_next = 3'd3;
                    partial_next = {17'd0, in_byte[3:0]};
                end else if (in_byte[3] == 1'b0) begin
                    exp_len_next = 3'd4;
                    partial_next = {18'd0, in_byte[2:0]};
                end else if (in_byte[2] == 1'b0) begin
                    exp_len_next = 3'd5;
                    partial_next = '0;
                end else begin
                    exp_len_next = 3'd6;
                    partial_next = '0;
                end
            end
        end
    end

    assign job_push = byte_accept && ((job.err_count != 3'd0) || (job.tail != TAIL_NONE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_len_reg <= 3'd0;
            taken_reg   <= 3'd0;
            partial_reg <= '0;
        end else if (byte_accept) begin
            exp_len_reg <= exp_len_next;
            taken_reg   <= taken_next;
            partial_reg <= partial_next;
        end
    end

endmodule

>>> rtl/core/usd_queue.sv
// ----------------------------------------------------------------------------
// usd_queue
// Short job queue that lets the front end and the back end stall apart.
// ----------------------------------------------------------------------------
module usd_queue import usd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  usd_job_t push_job,
    input  logic     pop,
    output logic     not_full,
    output logic     not_empty,
    output usd_job_t head_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    usd_job_t           slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_job  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/core/usd_back.sv
// ----------------------------------------------------------------------------
// usd_back
// Expands one job into its result words and drives the output register.
// ----------------------------------------------------------------------------
module usd_back import usd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               output_mode,
    input  logic               job_avail,
    input  usd_job_t           head_job,
    output logic               job_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [POINT_W-1:0] out_value,
    output logic               out_error,
    output logic               out_eos,
    output logic               out_last
);

    logic               job_valid_reg;
    logic [2:0]         errs_reg, errs_next;
    tail_kind_t         tail_reg;
    logic [POINT_W-1:0] point_reg;
    logic               half_reg, half_next;

    logic               out_valid_reg;
    logic [POINT_W-1:0] out_value_reg;
    logic               out_error_reg, out_eos_reg, out_last_reg;

    logic               load;
    logic [POINT_W-1:0] emit_value;
    logic               emit_error, emit_eos, emit_last;
    logic [POINT_W-1:0] supp_offset;
    logic               split;

    assign supp_offset = point_reg - SUPP_BASE;
    assign split       = output_mode && (point_reg > MAX_BMP);
    assign load        = job_valid_reg && (!out_valid_reg || out_ready);
    assign job_pop     = job_avail && (!job_valid_reg || (load && emit_last));

    always_comb begin
        emit_value = ERR_CHAR;
        emit_error = 1'b0;
        emit_eos   = 1'b0;
        emit_last  = 1'b1;
        errs_next  = errs_reg;
        half_next  = half_reg;
        if (errs_reg != 3'd0) begin
            emit_error = 1'b1;
            emit_last  = (errs_reg == 3'd1) && (tail_reg == TAIL_NONE);
            errs_next  = errs_reg - 3'd1;
        end else begin
            case (tail_reg)
                TAIL_EOS: begin
                    emit_value = '0;
                    emit_eos   = 1'b1;
                end
                TAIL_POINT: begin
                    // A supplementary point in UTF-16 mode goes out as two words.
                    if (split && !half_reg) begin
                        emit_value = {5'd0, SURR_HI_BASE + {6'd0, supp_offset[19:10]}};
                        emit_last  = 1'b0;
                        half_next  = 1'b1;
                    end else if (split) begin
                        emit_value = {5'd0, SURR_LO_BASE + {6'd0, supp_offset[9:0]}};
                    end else begin
                        emit_value = point_reg;
                    end
                end
                default: begin
                    emit_error = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (job_pop) begin
                job_valid_reg <= 1'b1;
            end else if (load && emit_last) begin
                job_valid_reg <= 1'b0;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            errs_reg  <= head_job.err_count;
            tail_reg  <= head_job.tail;
            point_reg <= head_job.point;
            half_reg  <= 1'b0;
        end else if (load) begin
            errs_reg <= errs_next;
            half_reg <= half_next;
        end
        if (load) begin
            out_value_reg <= emit_value;
            out_error_reg <= emit_error;
            out_eos_reg   <= emit_eos;
            out_last_reg  <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_error = out_error_reg;
    assign out_eos   = out_eos_reg;
    assign out_last  = out_last_reg;

endmodule
